// File: src/skdq_pkg.sv
// Shared types and constants for the short key deque.
`timescale 1ns / 1ps
package skdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KIND_W       = 3;
    localparam int HEAD_W       = 64;
    localparam int TAIL_W       = 8;
    localparam int KEY_W        = HEAD_W + TAIL_W;
    localparam int COUNT_W      = 5;

    localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PREPEND   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FIRST = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_LAST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PURGE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [HEAD_W-1:0] key_head;
        logic [TAIL_W-1:0] key_tail;
    } cmd_t;

    typedef struct packed {
        logic [HEAD_W-1:0]  entry_head;
        logic [TAIL_W-1:0]  entry_tail;
        logic               entry_valid;
        logic [COUNT_W-1:0] count_after;
        logic [COUNT_W-1:0] removed_count;
        logic               full_refused;
        logic               last_result;
    } rsp_t;

endpackage

// File: src/skdq_req_if.sv
// Request channel carrying one deque operation.
`timescale 1ns / 1ps
interface skdq_req_if
    import skdq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [HEAD_W-1:0] key_head;
    logic [TAIL_W-1:0] key_tail;

    modport source (output valid, kind, key_head, key_tail, input ready);
    modport sink   (input valid, kind, key_head, key_tail, output ready);
endinterface

// File: src/skdq_rsp_if.sv
// Result channel carrying one result of a deque operation.
`timescale 1ns / 1ps
interface skdq_rsp_if
    import skdq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [HEAD_W-1:0]  entry_head;
    logic [TAIL_W-1:0]  entry_tail;
    logic               entry_valid;
    logic [COUNT_W-1:0] count_after;
    logic [COUNT_W-1:0] removed_count;
    logic               full_refused;
    logic               last_result;

    modport source (output valid, entry_head, entry_tail, entry_valid, count_after,
                    removed_count, full_refused, last_result, input ready);
    modport sink   (input valid, entry_head, entry_tail, entry_valid, count_after,
                    removed_count, full_refused, last_result, output ready);
endinterface

// File: src/skdq_front.sv
// Front end: accepts requests, canonicalizes the key and queues the command.
`timescale 1ns / 1ps
module skdq_front
    import skdq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    skdq_req_if.sink     req,
    output logic         cmd_valid,
    output cmd_t         cmd,
    input  logic         cmd_pop
);

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        seen;
    cmd_t        canon;

    // A key ends at its first zero byte; everything after it reads as zero.
    always_comb
    begin
        seen           = 1'b0;
        canon.kind     = req.kind;
        canon.key_head = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (req.key_head[HEAD_W-1-8*b -: 8] == 8'd0)
            begin
                seen = 1'b1;
            end
            canon.key_head[HEAD_W-1-8*b -: 8] = seen ? 8'd0 : req.key_head[HEAD_W-1-8*b -: 8];
        end
        canon.key_tail = seen ? '0 : req.key_tail;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= canon;
        end
    end

endmodule

// File: src/skdq_back.sv
// Back end: ring buffer store, operation sequencer and result register.
`timescale 1ns / 1ps
module skdq_back
    import skdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RESULT = 3'd1;
    localparam logic [2:0] ST_DREAD  = 3'd2;
    localparam logic [2:0] ST_DEMIT  = 3'd3;
    localparam logic [2:0] ST_PREAD  = 3'd4;
    localparam logic [2:0] ST_PCMP   = 3'd5;

    logic [KEY_W-1:0] mem [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    first_reg, first_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    wptr_reg, wptr_next;
    logic [CW-1:0]    removed_reg, removed_next;
    logic             refused_reg, refused_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [KEY_W-1:0] wr_data;
    logic             out_free;
    logic [CW-1:0]    idx_inc;
    logic             at_end;
    logic             match;

    // Logical position to ring slot; the sum stays below twice the capacity.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign idx_inc   = idx_reg + 1'b1;
    assign at_end    = (idx_inc == count_reg);
    assign match     = (rd_data_reg == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        removed_next   = removed_reg;
        refused_next   = refused_reg;
        key_next       = key_reg;
        out_next       = out_reg;
        out_valid_next = (out_valid_reg && !rsp_ready);
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = phys(first_reg, wptr_reg);
        rd_addr        = phys(first_reg, idx_reg);
        wr_data        = {cmd.key_head, cmd.key_tail};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    removed_next = '0;
                    refused_next = 1'b0;
                    idx_next     = '0;
                    wptr_next    = '0;
                    key_next     = {cmd.key_head, cmd.key_tail};
                    state_next   = ST_RESULT;
                    case (cmd.kind)
                        KIND_APPEND:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(first_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_PREPEND:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                first_next = (first_reg == '0) ? LAST_A : first_reg - 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = first_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_REM_FIRST:
                        begin
                            if (count_reg != '0)
                            begin
                                first_next   = phys(first_reg, CW'(1));
                                count_next   = count_reg - 1'b1;
                                removed_next = CW'(1);
                            end
                        end
                        KIND_REM_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next   = count_reg - 1'b1;
                                removed_next = CW'(1);
                            end
                        end
                        KIND_PURGE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_PREAD;
                            end
                        end
                        KIND_DUMP:
                        begin
                            // An empty dump gives the same single result as the
                            // other kinds with nothing removed.
                            if (count_reg != '0)
                            begin
                                state_next = ST_DREAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.entry_head   = '0;
                    out_next.entry_tail   = '0;
                    out_next.entry_valid  = 1'b0;
                    out_next.count_after  = COUNT_W'(count_reg);
                    out_next.removed_count = COUNT_W'(removed_reg);
                    out_next.full_refused = refused_reg;
                    out_next.last_result  = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_DREAD:
            begin
                rd_en      = 1'b1;
                state_next = ST_DEMIT;
            end
            ST_DEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.entry_head    = rd_data_reg[KEY_W-1:TAIL_W];
                    out_next.entry_tail    = rd_data_reg[TAIL_W-1:0];
                    out_next.entry_valid   = 1'b1;
                    out_next.count_after   = COUNT_W'(count_reg);
                    out_next.removed_count = '0;
                    out_next.full_refused  = 1'b0;
                    out_next.last_result   = at_end;
                    idx_next               = idx_inc;
                    state_next             = at_end ? ST_IDLE : ST_DREAD;
                end
            end
            ST_PREAD:
            begin
                rd_en      = 1'b1;
                state_next = ST_PCMP;
            end
            ST_PCMP:
            begin
                // Survivors are copied down to the write position in order.
                if (match)
                begin
                    removed_next = removed_reg + 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_data   = rd_data_reg;
                    wptr_next = wptr_reg + 1'b1;
                end
                idx_next = idx_inc;
                if (at_end)
                begin
                    count_next = wptr_next;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_PREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wptr_reg      <= '0;
            removed_reg   <= '0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            wptr_reg      <= wptr_next;
            removed_reg   <= removed_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// File: src/short_key_deque_with_purge.sv
// Short key deque: one result per request, one per entry for a non-empty dump.
//
// The req channel carries one operation (append, prepend, remove first,
// remove last, remove all matching, dump) with a nine byte key; the rsp
// channel carries results, and last_result marks the final one of a request.
// A front end canonicalizes keys and holds up to two requests, so req can
// stay ready while the back end works. The back end keeps the entries in
// a ring buffer memory and runs one request at a time.
// Inserts and removals go through the result state to the result register.
// Remove all matching reads and compares each entry in turn; dump reads and
// emits each in turn, as set by the single registered memory read port.
// Reset empties the store at once; no clearing pass is run.
// When the receiver holds rsp.ready low, the result register keeps its
// contents and the back end waits; the front queue then fills and drops
// req.ready.
`timescale 1ns / 1ps
module short_key_deque_with_purge
    import skdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    skdq_req_if.sink   req,
    skdq_rsp_if.source rsp
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    rsp_t rsp_data;

    skdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    skdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    assign rsp.entry_head    = rsp_data.entry_head;
    assign rsp.entry_tail    = rsp_data.entry_tail;
    assign rsp.entry_valid   = rsp_data.entry_valid;
    assign rsp.count_after   = rsp_data.count_after;
    assign rsp.removed_count = rsp_data.removed_count;
    assign rsp.full_refused  = rsp_data.full_refused;
    assign rsp.last_result   = rsp_data.last_result;

endmodule

// File: src/skdq_checker.sv
// Port level checks for the short key deque, bound to the top level.
`timescale 1ns / 1ps
module skdq_checker
    import skdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [HEAD_W-1:0]  entry_head,
    input logic [TAIL_W-1:0]  entry_tail,
    input logic               entry_valid,
    input logic [COUNT_W-1:0] count_after,
    input logic [COUNT_W-1:0] removed_count,
    input logic               full_refused,
    input logic               last_result
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_head) && $stable(entry_tail)
            && $stable(count_after) && $stable(last_result))
        else $error("result changed while stalled");

    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !entry_valid |-> entry_head == '0 && entry_tail == '0 && last_result)
        else $error("result without entry carries entry data");

    a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_valid |-> removed_count == '0 && !full_refused
            && count_after != '0)
        else $error("dump result reports removal or refusal");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 31) || (count_after <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind short_key_deque_with_purge skdq_checker #(.CAPACITY(CAPACITY)) u_skdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .entry_head    (rsp.entry_head),
    .entry_tail    (rsp.entry_tail),
    .entry_valid   (rsp.entry_valid),
    .count_after   (rsp.count_after),
    .removed_count (rsp.removed_count),
    .full_refused  (rsp.full_refused),
    .last_result   (rsp.last_result)
);

// File: dv/skdq_tb_pkg.sv
// Result expectation type used by the deque testbench.
`timescale 1ns / 1ps
package skdq_tb_pkg;
    import skdq_pkg::*;

    // A queued expectation: one result of the block.
    typedef struct {
        logic [HEAD_W-1:0]  entry_head;
        logic [TAIL_W-1:0]  entry_tail;
        logic               entry_valid;
        logic [COUNT_W-1:0] count_after;
        logic [COUNT_W-1:0] removed_count;
        logic               full_refused;
        logic               last_result;
    } deque_result_t;
endpackage

// File: dv/short_key_deque_with_purge_tb.sv
// Self-checking testbench for the short key deque with purge.
`timescale 1ns / 1ps
module short_key_deque_with_purge_tb;
    import skdq_pkg::*;
    import skdq_tb_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF   = 300;

    logic clk;
    logic rst_n;

    skdq_req_if req_ch ();
    skdq_rsp_if rsp_ch ();

    short_key_deque_with_purge #(.CAPACITY(CAP)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Predictor state.
    logic [HEAD_W-1:0] model_heads[CAP];
    logic [TAIL_W-1:0] model_tails[CAP];
    int                model_count;

    deque_result_t     pending_results[$];
    int                error_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_rsp;
    int                idle_cycles;

    // Pool of keys so that purges hit stored entries often.
    logic [HEAD_W-1:0] pool_heads[8];
    logic [TAIL_W-1:0] pool_tails[8];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // A key ends at its first zero byte.
    function automatic void canonicalize(inout logic [HEAD_W-1:0] head,
                                         inout logic [TAIL_W-1:0] tail);
        logic [HEAD_W-1:0] kept;
        bit                ended;
        kept  = '0;
        ended = 1'b0;
        for (int b = 7; b >= 0; b--)
        begin
            if (head[b*8 +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                kept[b*8 +: 8] = head[b*8 +: 8];
        end
        head = kept;
        if (ended)
            tail = '0;
    endfunction

    function automatic deque_result_t status_result(int removed, bit refused);
        deque_result_t r;
        r.entry_head    = '0;
        r.entry_tail    = '0;
        r.entry_valid   = 1'b0;
        r.count_after   = COUNT_W'(model_count);
        r.removed_count = COUNT_W'(removed);
        r.full_refused  = refused;
        r.last_result   = 1'b1;
        return r;
    endfunction

    task automatic predict_deque(logic [KIND_W-1:0] kind, logic [HEAD_W-1:0] head,
                                 logic [TAIL_W-1:0] tail);
        int            removed;
        bit            refused;
        int            kept;
        deque_result_t r;
        removed = 0;
        refused = 1'b0;
        canonicalize(head, tail);
        case (kind)
            KIND_APPEND:
                if (model_count >= CAP)
                    refused = 1'b1;
                else
                begin
                    model_heads[model_count] = head;
                    model_tails[model_count] = tail;
                    model_count++;
                end
            KIND_PREPEND:
                if (model_count >= CAP)
                    refused = 1'b1;
                else
                begin
                    for (int i = model_count; i > 0; i--)
                    begin
                        model_heads[i] = model_heads[i-1];
                        model_tails[i] = model_tails[i-1];
                    end
                    model_heads[0] = head;
                    model_tails[0] = tail;
                    model_count++;
                end
            KIND_REM_FIRST:
                if (model_count > 0)
                begin
                    for (int i = 0; i + 1 < model_count; i++)
                    begin
                        model_heads[i] = model_heads[i+1];
                        model_tails[i] = model_tails[i+1];
                    end
                    model_count--;
                    removed = 1;
                end
            KIND_REM_LAST:
                if (model_count > 0)
                begin
                    model_count--;
                    removed = 1;
                end
            KIND_PURGE:
            begin
                kept = 0;
                for (int i = 0; i < model_count; i++)
                begin
                    if (model_heads[i] == head && model_tails[i] == tail)
                        removed++;
                    else
                    begin
                        model_heads[kept] = model_heads[i];
                        model_tails[kept] = model_tails[i];
                        kept++;
                    end
                end
                model_count = kept;
            end
            KIND_DUMP:
            begin
                if (model_count == 0)
                    pending_results.push_back(status_result(0, 1'b0));
                for (int i = 0; i < model_count; i++)
                begin
                    r = status_result(0, 1'b0);
                    r.entry_head  = model_heads[i];
                    r.entry_tail  = model_tails[i];
                    r.entry_valid = 1'b1;
                    r.last_result = (i + 1 == model_count);
                    pending_results.push_back(r);
                end
                return;
            end
            default: ;
        endcase
        pending_results.push_back(status_result(removed, refused));
    endtask

    // Sends one request and records its expected results on acceptance.
    // Valid stays high after acceptance; the caller drops it when done.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [HEAD_W-1:0] head,
                                logic [TAIL_W-1:0] tail);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.key_head <= head;
        req_ch.key_tail <= tail;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_deque(kind, head, tail);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [HEAD_W-1:0] random_head();
        return {$urandom(), $urandom()};
    endfunction

    // Random request: mostly keys from the pool, with inserts the most common kind.
    task automatic send_random_request();
        logic [KIND_W-1:0] kind;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
        int                p;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 45)
            kind = $urandom_range(1) ? KIND_APPEND : KIND_PREPEND;
        else if (roll < 60)
            kind = KIND_PURGE;
        else if (roll < 72)
            kind = KIND_REM_FIRST;
        else if (roll < 84)
            kind = KIND_REM_LAST;
        else if (roll < 96)
            kind = KIND_DUMP;
        else
            kind = KIND_W'($urandom_range(7));
        p = $urandom_range(7);
        if ($urandom_range(3) == 0)
        begin
            head = random_head();
            tail = $urandom();
        end
        else
        begin
            head = pool_heads[p];
            tail = pool_tails[p];
        end
        send_request(kind, head, tail);
    endtask

    task automatic test_directed();
        send_request(KIND_DUMP, '0, '0);
        send_request(KIND_REM_FIRST, '0, '0);
        send_request(KIND_REM_LAST, '0, '0);
        send_request(KIND_PURGE, '1, '1);
        send_request(KIND_APPEND, '1, '1);
        send_request(KIND_PREPEND, '0, 8'hFF);
        // Bytes after the first zero byte are dropped.
        send_request(KIND_APPEND, 64'h4142_0043_4445_4647, 8'h48);
        send_request(KIND_APPEND, 64'h4142_0000_0000_0000, 8'h00);
        send_request(KIND_APPEND, 64'h4142_4344_4546_4700, 8'h55);
        send_request(KIND_DUMP, '0, '0);
        send_request(KIND_PURGE, 64'h4142_00FF_0000_0001, 8'h7);
        send_request(KIND_W'(6), '1, '1);
        send_request(KIND_W'(7), '1, '1);
        for (int i = 0; i < CAP; i++)
            send_request(KIND_APPEND, 64'h5A00_0000_0000_0000, 8'h00);
        send_request(KIND_APPEND, '1, '1);
        send_request(KIND_PREPEND, '1, '1);
        send_request(KIND_DUMP, '0, '0);
        send_request(KIND_PURGE, 64'h5A00_0000_0000_0000, 8'h00);
        send_request(KIND_REM_FIRST, '0, '0);
        send_request(KIND_REM_LAST, '0, '0);
        send_request(KIND_DUMP, '0, '0);
        req_ch.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_request();
        req_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // The receiver holds off while requests keep coming, filling the front end.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rsp       = 1'b1;
        fork
            begin
                repeat (HOLD_OFF) @(posedge clk);
                hold_rsp = 1'b0;
            end
            begin
                repeat (20) send_random_request();
                req_ch.valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending");
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp_ch.entry_head !== e.entry_head)
                begin
                    $error("entry_head exp %h got %h", e.entry_head, rsp_ch.entry_head);
                    error_count++;
                end
                if (rsp_ch.entry_tail !== e.entry_tail)
                begin
                    $error("entry_tail exp %h got %h", e.entry_tail, rsp_ch.entry_tail);
                    error_count++;
                end
                if (rsp_ch.entry_valid !== e.entry_valid)
                begin
                    $error("entry_valid exp %b got %b", e.entry_valid, rsp_ch.entry_valid);
                    error_count++;
                end
                if (rsp_ch.count_after !== e.count_after)
                begin
                    $error("count_after exp %0d got %0d", e.count_after, rsp_ch.count_after);
                    error_count++;
                end
                if (rsp_ch.removed_count !== e.removed_count)
                begin
                    $error("removed_count exp %0d got %0d", e.removed_count,
                           rsp_ch.removed_count);
                    error_count++;
                end
                if (rsp_ch.full_refused !== e.full_refused)
                begin
                    $error("full_refused exp %b got %b", e.full_refused, rsp_ch.full_refused);
                    error_count++;
                end
                if (rsp_ch.last_result !== e.last_result)
                begin
                    $error("last_result exp %b got %b", e.last_result, rsp_ch.last_result);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls, driven at the rising edge.
    always @(posedge clk)
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("short_key_deque_with_purge regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.key_head = '0;
        req_ch.key_tail = '0;
        rsp_ch.ready    = 1'b0;
        hold_rsp        = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        idle_cycles     = 0;
        model_count     = 0;
        for (int i = 0; i < 8; i++)
        begin
            pool_heads[i] = random_head();
            pool_tails[i] = $urandom();
        end
        // Short and empty keys in the pool too.
        pool_heads[6] = {pool_heads[6][63:40], 40'h0};
        pool_heads[7] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(110, 0, 0);
        test_random_phase(100, 62, 0);
        test_random_phase(100, 0, 62);
        test_random_phase(100, 35, 35);
        test_backpressure();

        if (error_count == 0)
            $display("short_key_deque_with_purge regression: pass");
        else
            $display("short_key_deque_with_purge regression: fail");
        $finish;
    end
endmodule

// File: sim.f
src/skdq_pkg.sv
src/skdq_req_if.sv
src/skdq_rsp_if.sv
src/skdq_front.sv
src/skdq_back.sv
src/short_key_deque_with_purge.sv
src/skdq_checker.sv
dv/skdq_tb_pkg.sv
dv/short_key_deque_with_purge_tb.sv
